>>> rtl/pm_pkg.sv
package pm_pkg;

    localparam int MAX_LEN     = 32;
    localparam int COEF_WIDTH  = 16;
    localparam int IN_W        = 16;
    localparam int ACC_W       = 40;
    localparam int PROD_W      = 2 * COEF_WIDTH;
    localparam int SUM_W       = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int IDX_W       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int K_W         = $clog2(2 * MAX_LEN);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [LEN_W-1:0]  LEN_MAX = LEN_W'(MAX_LEN);
    localparam logic [QPTR_W:0]   Q_FULL  = (QPTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] Q_LAST  = QPTR_W'(QUEUE_DEPTH - 1);

    typedef logic signed [COEF_WIDTH-1:0] t_coef;
    typedef logic signed [ACC_W-1:0]      t_acc;

    typedef struct packed {
        logic              wr_en;
        logic              wr_second;
        logic              run;
        logic [IDX_W-1:0]  idx;
        t_coef             coef;
        logic [LEN_W-1:0]  a_len;
        logic [LEN_W-1:0]  b_len;
        logic              a_zero;
        logic              ovf;
    } t_cmd;

    function automatic t_coef coef_ext(input logic [IN_W-1:0] raw);
        logic [IN_W+31:0] w;
        w = {32'b0, raw};
        return w[COEF_WIDTH-1:0];
    endfunction

    function automatic t_acc sat_acc(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-ACC_W:0] top;
        top = s[SUM_W-1:ACC_W-1];
        if ((&top) || !(|top)) begin
            return s[ACC_W-1:0];
        end else if (s[SUM_W-1]) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

endpackage

>>> rtl/pm_front.sv
module pm_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_operand_select,
    input  logic signed [15:0]     i_coefficient,
    input  logic                   i_last_coeff,
    output logic                   o_push,
    output pm_pkg::t_cmd           o_cmd,
    input  logic                   i_full
);

    logic [pm_pkg::LEN_W-1:0] r_a_len, n_a_len;
    logic [pm_pkg::LEN_W-1:0] r_b_len, n_b_len;
    logic                     r_ovf, n_ovf;
    logic                     r_closed, n_closed;
    logic                     accept;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        n_a_len  = r_a_len;
        n_b_len  = r_b_len;
        n_ovf    = r_ovf;
        n_closed = r_closed;
        o_push   = 1'b0;
        o_cmd    = '0;
        o_cmd.coef = pm_pkg::coef_ext(i_coefficient);
        if (accept) begin
            if (!i_operand_select) begin
                if (r_closed) begin
                    n_a_len = '0;
                    n_b_len = '0;
                    n_ovf   = 1'b0;
                end
                if (n_a_len < pm_pkg::LEN_MAX) begin
                    o_push          = 1'b1;
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.wr_second = 1'b0;
                    o_cmd.idx       = n_a_len[pm_pkg::IDX_W-1:0];
                    n_a_len         = n_a_len + pm_pkg::LEN_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
                n_closed = i_last_coeff;
            end else begin
                n_closed = 1'b1;
                if (r_b_len < pm_pkg::LEN_MAX) begin
                    o_push          = 1'b1;
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.wr_second = 1'b1;
                    o_cmd.idx       = r_b_len[pm_pkg::IDX_W-1:0];
                    n_b_len         = r_b_len + pm_pkg::LEN_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
                if (i_last_coeff) begin
                    o_push       = 1'b1;
                    o_cmd.run    = 1'b1;
                    o_cmd.a_zero = (r_a_len == '0);
                    o_cmd.a_len  = (r_a_len == '0) ? pm_pkg::LEN_W'(1) : r_a_len;
                    o_cmd.b_len  = n_b_len;
                    o_cmd.ovf    = n_ovf;
                    n_a_len      = '0;
                    n_b_len      = '0;
                    n_ovf        = 1'b0;
                    n_closed     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_len  <= '0;
            r_b_len  <= '0;
            r_ovf    <= 1'b0;
            r_closed <= 1'b0;
        end else begin
            r_a_len  <= n_a_len;
            r_b_len  <= n_b_len;
            r_ovf    <= n_ovf;
            r_closed <= n_closed;
        end
    end

endmodule

>>> rtl/pm_queue.sv
module pm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pm_pkg::t_cmd  i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output pm_pkg::t_cmd  o_cmd,
    output logic          o_valid
);

    pm_pkg::t_cmd              r_mem [pm_pkg::QUEUE_DEPTH];
    logic [pm_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [pm_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [pm_pkg::QPTR_W:0]   r_count;
    logic                      do_push;
    logic                      do_pop;

    assign o_full  = (r_count == pm_pkg::Q_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == pm_pkg::Q_LAST) ? '0 : r_wr_ptr + pm_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == pm_pkg::Q_LAST) ? '0 : r_rd_ptr + pm_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (pm_pkg::QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (pm_pkg::QPTR_W + 1)'(1);
            end
        end
    end

endmodule

>>> rtl/pm_back.sv
module pm_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    input  pm_pkg::t_cmd                     i_cmd,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [pm_pkg::ACC_W-1:0]  o_product_coeff,
    output logic                             o_result_last,
    output logic                             o_length_overflow
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    typedef struct packed {
        logic first;
        logic last_term;
        logic last_res;
        logic ovf;
        logic zero;
    } t_tag;

    t_state                      r_state;
    pm_pkg::t_coef               r_mem_a [pm_pkg::MAX_LEN];
    pm_pkg::t_coef               r_mem_b [pm_pkg::MAX_LEN];

    logic [pm_pkg::LEN_W-1:0]    r_ad;
    logic [pm_pkg::LEN_W-1:0]    r_sl;
    logic                        r_zero;
    logic                        r_ovf;
    logic [pm_pkg::K_W-1:0]      r_rd_last;
    logic [pm_pkg::K_W-1:0]      r_k;
    logic [pm_pkg::IDX_W-1:0]    r_i;
    logic                        r_first;

    logic                        r_s1_valid;
    t_tag                        r_s1_tag;
    pm_pkg::t_coef               r_s1_a;
    pm_pkg::t_coef               r_s1_b;
    logic                        r_s2_valid;
    t_tag                        r_s2_tag;
    logic signed [pm_pkg::PROD_W-1:0] r_s2_prod;
    pm_pkg::t_acc                r_acc;

    logic                        r_out_valid;
    pm_pkg::t_acc                r_out_coeff;
    logic                        r_out_last;
    logic                        r_out_ovf;

    logic                        adv;
    logic                        pop;
    logic                        issue;
    logic [pm_pkg::K_W-1:0]      i_ext;
    logic [pm_pkg::K_W-1:0]      j_full;
    logic [pm_pkg::K_W-1:0]      a_hi;
    logic [pm_pkg::K_W-1:0]      i_hi;
    logic                        last_term;
    logic                        last_res;
    logic [pm_pkg::K_W-1:0]      k_nx;
    logic [pm_pkg::K_W-1:0]      sl_ext;
    logic [pm_pkg::K_W-1:0]      lo_nx;
    logic [pm_pkg::LEN_W:0]      len_sum;
    t_tag                        tag;
    logic signed [pm_pkg::PROD_W-1:0] prod;
    pm_pkg::t_acc                acc_base;
    logic signed [pm_pkg::SUM_W-1:0]  sum;
    pm_pkg::t_acc                acc_n;

    assign adv   = !r_out_valid || i_out_ready;
    assign pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign issue = (r_state == S_RUN) && adv;
    assign o_pop = pop;

    always_comb begin
        i_ext     = pm_pkg::K_W'(r_i);
        j_full    = r_k - i_ext;
        a_hi      = pm_pkg::K_W'(r_ad) - pm_pkg::K_W'(1);
        i_hi      = (a_hi <= r_k) ? a_hi : r_k;
        last_term = (i_ext == i_hi);
        last_res  = (r_k == r_rd_last);
        k_nx      = r_k + pm_pkg::K_W'(1);
        sl_ext    = pm_pkg::K_W'(r_sl);
        lo_nx     = (k_nx >= sl_ext) ? (k_nx - sl_ext + pm_pkg::K_W'(1)) : '0;
        len_sum   = {1'b0, i_cmd.a_len} + {1'b0, i_cmd.b_len} - (pm_pkg::LEN_W + 1)'(2);
        tag.first     = r_first;
        tag.last_term = last_term;
        tag.last_res  = last_res;
        tag.ovf       = r_ovf;
        tag.zero      = r_zero;
        prod      = r_s1_a * r_s1_b;
        if (r_s2_tag.first) begin
            acc_base = '0;
        end else begin
            acc_base = r_acc;
        end
        sum   = pm_pkg::SUM_W'(acc_base) + pm_pkg::SUM_W'(r_s2_prod);
        acc_n = pm_pkg::sat_acc(sum);
    end

    // store writes and stage-1 operand reads
    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.wr_en) begin
            if (i_cmd.wr_second) begin
                r_mem_b[i_cmd.idx] <= i_cmd.coef;
            end else begin
                r_mem_a[i_cmd.idx] <= i_cmd.coef;
            end
        end
        if (issue) begin
            r_s1_a <= r_mem_a[r_i];
            r_s1_b <= r_mem_b[j_full[pm_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (pop && i_cmd.run) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (issue && last_term && last_res) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (adv) begin
                r_s1_valid  <= issue;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid && r_s2_tag.last_term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.run) begin
            r_ad      <= i_cmd.a_len;
            r_sl      <= i_cmd.b_len;
            r_zero    <= i_cmd.a_zero;
            r_ovf     <= i_cmd.ovf;
            r_rd_last <= pm_pkg::K_W'(len_sum);
            r_k       <= '0;
            r_i       <= '0;
            r_first   <= 1'b1;
        end else if (issue) begin
            if (last_term) begin
                if (!last_res) begin
                    r_k     <= k_nx;
                    r_i     <= lo_nx[pm_pkg::IDX_W-1:0];
                    r_first <= 1'b1;
                end
            end else begin
                r_i     <= r_i + pm_pkg::IDX_W'(1);
                r_first <= 1'b0;
            end
        end
        if (adv) begin
            r_s1_tag  <= tag;
            r_s2_tag  <= r_s1_tag;
            r_s2_prod <= r_s1_tag.zero ? '0 : prod;
            if (r_s2_valid) begin
                r_acc <= acc_n;
            end
            if (r_s2_valid && r_s2_tag.last_term) begin
                r_out_coeff <= acc_n;
                r_out_last  <= r_s2_tag.last_res;
                r_out_ovf   <= r_s2_tag.ovf;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_product_coeff   = r_out_coeff;
    assign o_result_last     = r_out_last;
    assign o_length_overflow = r_out_ovf;

endmodule

>>> rtl/polynomial_multiply.sv
// Channel  | Handshake                    | Word
// ---------+------------------------------+-----------------------------------------------
// input    | i_in_valid / o_in_ready      | i_operand_select, i_coefficient, i_last_coeff
// output   | o_out_valid / i_out_ready    | o_product_coeff, o_result_last, o_length_overflow
//
// Loading words are taken one per cycle while the 4-entry command queue has room.
// A product of an A-term and a B-term polynomial is computed term by term on the single
// multiply-accumulate unit; with an idle back end the closing word passes through the command
// queue, the operand read, the product register and the output register before its first result.
// Synchronous active-low reset clears control state; coefficient stores are not cleared.
// An output stall freezes the multiply pipeline; the queue keeps taking input words.
module polynomial_multiply (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_operand_select,
    input  logic signed [15:0]   i_coefficient,
    input  logic                 i_last_coeff,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [39:0]   o_product_coeff,
    output logic                 o_result_last,
    output logic                 o_length_overflow
);

    logic         push;
    logic         full;
    logic         pop;
    logic         cmd_valid;
    pm_pkg::t_cmd front_cmd;
    pm_pkg::t_cmd back_cmd;

    pm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operand_select (i_operand_select),
        .i_coefficient    (i_coefficient),
        .i_last_coeff     (i_last_coeff),
        .o_push           (push),
        .o_cmd            (front_cmd),
        .i_full           (full)
    );

    pm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (back_cmd),
        .o_valid (cmd_valid)
    );

    pm_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (cmd_valid),
        .i_cmd             (back_cmd),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_product_coeff   (o_product_coeff),
        .o_result_last     (o_result_last),
        .o_length_overflow (o_length_overflow)
    );

endmodule

>>> rtl/pm_checker.sv
module pm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [39:0] o_product_coeff,
    input logic               o_result_last,
    input logic               o_length_overflow
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_product_coeff) && $stable(o_result_last)))
        else $error("output word changed while stalled");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_result_last) |=>
            (!o_out_valid || (o_length_overflow == $past(o_length_overflow))))
        else $error("overflow flag changed within one product");

endmodule

bind polynomial_multiply pm_checker u_pm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_product_coeff   (o_product_coeff),
    .o_result_last     (o_result_last),
    .o_length_overflow (o_length_overflow)
);

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned HOLD_LEN    = 300;
    localparam int unsigned HOLD_AT     = 150;
    localparam int unsigned WORD_TARGET = 410;
    localparam logic signed [47:0] SUM_HI = 48'sd549755813887;
    localparam logic signed [47:0] SUM_LO = -48'sd549755813888;

    typedef struct packed {
        bit            sel;
        pm_pkg::t_coef coef;
        bit            is_last;
    } t_word;

    typedef struct packed {
        pm_pkg::t_acc value;
        bit           is_last;
        bit           ovf;
    } t_coeff;

    logic               i_clk             = 1'b0;
    logic               i_rst_n           = 1'b0;
    logic               i_in_valid        = 1'b0;
    logic               o_in_ready;
    logic               i_operand_select  = 1'b0;
    logic signed [15:0] i_coefficient     = '0;
    logic               i_last_coeff      = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready       = 1'b0;
    logic signed [39:0] o_product_coeff;
    logic               o_result_last;
    logic               o_length_overflow;

    polynomial_multiply u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operand_select  (i_operand_select),
        .i_coefficient     (i_coefficient),
        .i_last_coeff      (i_last_coeff),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_product_coeff   (o_product_coeff),
        .o_result_last     (o_result_last),
        .o_length_overflow (o_length_overflow)
    );

    t_word  pending_words[$];
    t_coeff expected_coeffs[$];

    pm_pkg::t_coef first_terms[pm_pkg::MAX_LEN];
    pm_pkg::t_coef second_terms[pm_pkg::MAX_LEN];
    int unsigned first_count  = 0;
    int unsigned second_count = 0;
    bit          terms_dropped = 1'b0;
    bit          first_done    = 1'b0;

    int unsigned error_count   = 0;
    int unsigned words_in      = 0;
    int unsigned coeffs_out    = 0;
    int unsigned products_seen = 0;
    int unsigned dropped_seen  = 0;
    int unsigned in_gap        = 0;
    int unsigned out_wait      = 0;
    int unsigned stall_cycles  = 0;
    int unsigned hold_cnt      = 0;
    bit          hold_off      = 1'b0;
    bit          hold_done     = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string msg);
        if (error_count < 20) begin
            $display("MISMATCH at %0t ns: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic clear_operands();
        first_count   = 0;
        second_count  = 0;
        terms_dropped = 1'b0;
        first_done    = 1'b0;
    endtask

    // Convolve the stored operands once the second one closes.
    task automatic convolve_word(input bit sel, input pm_pkg::t_coef coef, input bit is_last);
        int unsigned      na;
        int unsigned      nr;
        int unsigned      j;
        logic signed [47:0] acc;
        t_coeff           res;
        if (!sel) begin
            if (first_done) begin
                clear_operands();
            end
            if (first_count < pm_pkg::MAX_LEN) begin
                first_terms[first_count] = coef;
                first_count++;
            end else begin
                terms_dropped = 1'b1;
            end
            if (is_last) begin
                first_done = 1'b1;
            end
        end else begin
            first_done = 1'b1;
            if (second_count < pm_pkg::MAX_LEN) begin
                second_terms[second_count] = coef;
                second_count++;
            end else begin
                terms_dropped = 1'b1;
            end
            if (is_last) begin
                na = first_count;
                if (na == 0) begin
                    first_terms[0] = '0;
                    na = 1;
                end
                nr = na + second_count - 1;
                for (int unsigned k = 0; k < nr; k++) begin
                    acc = '0;
                    for (int unsigned i = 0; i < na && i <= k; i++) begin
                        j = k - i;
                        if (j < second_count) begin
                            acc = acc + first_terms[i] * second_terms[j];
                            if (acc > SUM_HI) begin
                                acc = SUM_HI;
                            end
                            if (acc < SUM_LO) begin
                                acc = SUM_LO;
                            end
                        end
                    end
                    res.value   = acc[39:0];
                    res.is_last = (k + 1 == nr);
                    res.ovf     = terms_dropped;
                    expected_coeffs.push_back(res);
                end
                products_seen++;
                if (terms_dropped) begin
                    dropped_seen++;
                end
                clear_operands();
            end
        end
    endtask

    function automatic pm_pkg::t_coef draw_coef();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return pm_pkg::t_coef'($urandom);
        endcase
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(9, 32);
        end
        return $urandom_range(1, 8);
    endfunction

    task automatic put_word(input bit sel, input pm_pkg::t_coef coef, input bit is_last);
        t_word w;
        w.sel     = sel;
        w.coef    = coef;
        w.is_last = is_last;
        pending_words.push_back(w);
    endtask

    task automatic add_poly(input bit sel, input int n, input bit ends);
        for (int i = 0; i < n; i++) begin
            put_word(sel, draw_coef(), ends && (i == n - 1));
        end
    endtask

    // Sender: present words from the pending queue, predict on acceptance.
    always @(posedge i_clk) begin : drive_words
        t_word nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                convolve_word(i_operand_select, i_coefficient, i_last_coeff);
                words_in <= words_in + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap != 0) begin
                    in_gap     <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    nxt = pending_words.pop_front();
                    i_operand_select <= nxt.sel;
                    i_coefficient    <= nxt.coef;
                    i_last_coeff     <= nxt.is_last;
                    i_in_valid       <= 1'b1;
                    in_gap <= (((words_in / 50) % 3) == 1) ? 0 : $urandom_range(0, 3);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted word against the oldest expectation.
    always @(posedge i_clk) begin : take_results
        int unsigned w;
        t_coeff      exp_c;
        w = 0;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_wait    <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                coeffs_out <= coeffs_out + 1;
                if (expected_coeffs.size() == 0) begin
                    note_mismatch($sformatf("unexpected result word %0d", o_product_coeff));
                end else begin
                    exp_c = expected_coeffs.pop_front();
                    if (o_product_coeff !== exp_c.value) begin
                        note_mismatch($sformatf("product_coeff %0d, want %0d",
                                                o_product_coeff, exp_c.value));
                    end
                    if (o_result_last !== exp_c.is_last) begin
                        note_mismatch($sformatf("result_last %b, want %b",
                                                o_result_last, exp_c.is_last));
                    end
                    if (o_length_overflow !== exp_c.ovf) begin
                        note_mismatch($sformatf("length_overflow %b, want %b",
                                                o_length_overflow, exp_c.ovf));
                    end
                end
                w = (((coeffs_out / 60) % 3) == 2) ? 0 : $urandom_range(0, 3);
            end
            if (hold_off) begin
                i_out_ready <= 1'b0;
            end else if (o_out_valid && i_out_ready) begin
                out_wait    <= w;
                i_out_ready <= (w == 0);
            end else if (out_wait != 0) begin
                out_wait    <= out_wait - 1;
                i_out_ready <= (out_wait == 1);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Hold off the receiver once so the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off  <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (hold_off) begin
            if (hold_cnt == HOLD_LEN) begin
                hold_off  <= 1'b0;
                hold_done <= 1'b1;
            end else begin
                hold_cnt <= hold_cnt + 1;
            end
        end else if (!hold_done && words_in >= HOLD_AT) begin
            hold_off <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_coeffs.size());
            $display("polynomial_multiply test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int kind;
        int la;
        int lb;

        // empty first operand against full-scale terms
        put_word(1'b1, 16'sh7fff, 1'b0);
        put_word(1'b1, 16'sh8000, 1'b1);
        // restart of a closed first operand, extreme products
        put_word(1'b0, 16'sh8000, 1'b1);
        put_word(1'b0, 16'sh8000, 1'b0);
        put_word(1'b0, 16'sh7fff, 1'b1);
        put_word(1'b1, 16'sh8000, 1'b0);
        put_word(1'b1, 16'sh8000, 1'b1);
        // second operand before the first one closed
        put_word(1'b0, 16'sh0001, 1'b0);
        put_word(1'b0, 16'sh0002, 1'b0);
        put_word(1'b1, 16'sh0003, 1'b1);
        // single terms
        put_word(1'b0, 16'sh7fff, 1'b1);
        put_word(1'b1, 16'sh7fff, 1'b1);
        // first operand reloaded while the second is open
        put_word(1'b0, 16'sh0005, 1'b1);
        put_word(1'b1, 16'sh0007, 1'b0);
        put_word(1'b0, 16'sh0009, 1'b1);
        put_word(1'b1, 16'sh000b, 1'b1);
        // alternating bit patterns
        put_word(1'b0, 16'sh5555, 1'b1);
        put_word(1'b1, 16'shaaaa, 1'b1);

        while (pending_words.size() < WORD_TARGET) begin
            kind = $urandom_range(0, 9);
            la   = pick_len();
            lb   = pick_len();
            case (kind)
                6: begin
                    if ($urandom_range(0, 1)) begin
                        la = $urandom_range(pm_pkg::MAX_LEN + 1, pm_pkg::MAX_LEN + 4);
                    end else begin
                        lb = $urandom_range(pm_pkg::MAX_LEN + 1, pm_pkg::MAX_LEN + 4);
                    end
                    add_poly(1'b0, la, 1'b1);
                    add_poly(1'b1, lb, 1'b1);
                end
                7: begin
                    add_poly(1'b0, la, 1'b0);
                    add_poly(1'b1, lb, 1'b1);
                end
                8: begin
                    repeat ($urandom_range(1, 4)) begin
                        put_word(1'($urandom_range(0, 1)), draw_coef(),
                                 1'($urandom_range(0, 1)));
                    end
                end
                9: begin
                    add_poly(1'b0, la, 1'b1);
                    add_poly(1'b1, lb, 1'b0);
                end
                default: begin
                    add_poly(1'b0, la, 1'b1);
                    add_poly(1'b1, lb, 1'b1);
                end
            endcase
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (expected_coeffs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (50) @(posedge i_clk);

        $display("sent %0d coefficient words, checked %0d product coefficients",
                 words_in, coeffs_out);
        $display("%0d products, %0d of them with dropped terms, %0d mismatches",
                 products_seen, dropped_seen, error_count);
        if (error_count == 0) begin
            $display("polynomial_multiply test passed");
        end else begin
            $display("polynomial_multiply test failed");
        end
        $finish;
    end

endmodule
